// ===== hdl/mom_pkg.sv =====
// Shared widths and types for the Mandelbrot orbit magnitude block.
// Used by mom_mul, mom_sqrt and mandelbrot_orbit_magnitude; depends on nothing.
package mom_pkg;

   localparam int CoordWidth = 16;   // c parts, Q3.13
   localparam int ZWidth     = 32;   // z parts, Q8.24
   localparam int ProdWidth  = 64;   // exact products, Q16.48
   localparam int CountWidth = 11;   // iteration count register
   localparam int MagWidth   = 24;   // magnitude, Q8.16
   localparam int RadWidth   = 48;   // square root radicand
   localparam int StepWidth  = 5;    // square root step counter

   localparam logic [CountWidth-1:0] CountReset = CountWidth'(100);
   localparam logic [MagWidth-1:0]   MagMax     = {MagWidth{1'b1}};

   typedef struct packed {
      logic                done;
      logic [MagWidth-1:0] root;
   } sqrt_status_type;

endpackage

// ===== hdl/mom_mul.sv =====
// Registered 32 x 32 signed multiplier shared by all orbit and magnitude products.
// Depends on mom_pkg for the operand and product widths.
module mom_mul
   import mom_pkg::*;
(
   input  logic                        clock,
   input  logic signed [ZWidth-1:0]    op_a,
   input  logic signed [ZWidth-1:0]    op_b,
   output logic signed [ProdWidth-1:0] product
);

   logic signed [ProdWidth-1:0] prod_ff;
   logic signed [ProdWidth-1:0] prod_in;

   assign prod_in = ProdWidth'(op_a) * ProdWidth'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

// ===== hdl/mom_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on mom_pkg for widths and the status struct.
module mom_sqrt
   import mom_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RadWidth-1:0]   radicand,
   output sqrt_status_type       status
);

   localparam logic [StepWidth-1:0] LastStep = StepWidth'(MagWidth - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic [RadWidth-1:0]   rad_ff, rad_in;
   logic [MagWidth+1:0]   rem_ff, rem_in;
   logic [MagWidth-1:0]   root_ff, root_in;

   logic [MagWidth+3:0]   rem_shift;
   logic [MagWidth+3:0]   trial;
   logic [MagWidth+3:0]   rem_sub;

   // Bring down the next two radicand bits and try root*4+1 against them.
   assign rem_shift = {rem_ff, rad_ff[RadWidth-1 -: 2]};
   assign trial     = (MagWidth+4)'({root_ff, 2'b01});
   assign rem_sub   = rem_shift - trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RadWidth-3:0], 2'b00};
         step_in = step_ff + StepWidth'(1);
         if (rem_shift >= trial) begin
            rem_in  = rem_sub[MagWidth+1:0];
            root_in = {root_ff[MagWidth-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift[MagWidth+1:0];
            root_in = {root_ff[MagWidth-2:0], 1'b0};
         end
         if (step_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign status.done = done_ff;
   assign status.root = root_ff;

endmodule

// ===== hdl/mandelbrot_orbit_magnitude.sv =====
// Mandelbrot orbit magnitude: iterates z = z*z + c for one point, then returns |z|.
// Depends on mom_pkg, mom_mul (shared multiplier) and mom_sqrt (square root unit).
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_c_real, req_c_imag (Q3.13)
//   rsp      out        rsp_valid / rsp_ready   rsp_magnitude (Q8.16), rsp_saturated
//   csr      in         csr_valid / csr_ready   csr_iteration_count
//
// A request runs up to n orbit steps, n being the iteration count clamped to
// ITER_LIMIT: each step uses the single multiplier in S_SQ_R, S_SQ_I and S_CROSS,
// and the magnitude takes two more products, a sum and a square root. An overflow
// ends the orbit early. req_ready is high only while no request is in work; a finished
// result waits in the output register. Reset is synchronous and sets the count to 100.
module mandelbrot_orbit_magnitude
   import mom_pkg::*;
#(
   parameter int ITER_LIMIT = 1024
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [CoordWidth-1:0]  req_c_real,
   input  logic signed [CoordWidth-1:0]  req_c_imag,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [MagWidth-1:0]           rsp_magnitude,
   output logic                          rsp_saturated,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CountWidth-1:0]         csr_iteration_count
);

   localparam int CountMax = (1 << CountWidth) - 1;
   localparam int CapValue = (ITER_LIMIT < CountMax) ? ITER_LIMIT : CountMax;
   localparam logic [CountWidth-1:0] CountCap = CountWidth'(CapValue);
   localparam int SumWidth = ProdWidth - 22;   // room for a shifted product plus c

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_SQ_R    = 10'b0000000010,
      S_SQ_I    = 10'b0000000100,
      S_CROSS   = 10'b0000001000,
      S_UPDATE  = 10'b0000010000,
      S_MAG_R   = 10'b0000100000,
      S_MAG_I   = 10'b0001000000,
      S_MAG_SUM = 10'b0010000000,
      S_ROOT    = 10'b0100000000,
      S_EMIT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [CountWidth-1:0]        count_ff, count_in;
   logic [CountWidth-1:0]        steps_ff, steps_in;
   logic [CountWidth-1:0]        step_ff, step_in;
   logic signed [CoordWidth-1:0] c_real_ff, c_real_in;
   logic signed [CoordWidth-1:0] c_imag_ff, c_imag_in;
   logic signed [ZWidth-1:0]     z_real_ff, z_real_in;
   logic signed [ZWidth-1:0]     z_imag_ff, z_imag_in;
   logic signed [ProdWidth-1:0]  rr_ff, rr_in;
   logic signed [ProdWidth-1:0]  diff_ff, diff_in;
   logic [MagWidth-1:0]          mag_ff, mag_in;
   logic                         sat_ff, sat_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [MagWidth-1:0]          rsp_mag_ff, rsp_mag_in;
   logic                         rsp_sat_ff, rsp_sat_in;

   logic signed [ZWidth-1:0]     op_a;
   logic signed [ZWidth-1:0]     op_b;
   logic signed [ProdWidth-1:0]  product;
   logic [CountWidth-1:0]        req_steps;
   logic signed [SumWidth-1:0]   c_real_wide;
   logic signed [SumWidth-1:0]   c_imag_wide;
   logic signed [SumWidth-1:0]   new_real;
   logic signed [SumWidth-1:0]   new_imag;
   logic                         overflow;
   logic [ProdWidth-1:0]         sq_sum;
   logic                         root_start;
   sqrt_status_type              root_status;

   mom_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   mom_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sq_sum[ProdWidth-1 -: RadWidth]),
      .status   (root_status)
   );

   always_comb begin
      case (state_ff)
         S_SQ_R, S_MAG_R: begin
            op_a = z_real_ff;
            op_b = z_real_ff;
         end
         S_SQ_I, S_MAG_I: begin
            op_a = z_imag_ff;
            op_b = z_imag_ff;
         end
         default: begin
            op_a = z_real_ff;
            op_b = z_imag_ff;
         end
      endcase
   end

   assign req_steps   = (count_ff > CountCap) ? CountCap : count_ff;
   assign c_real_wide = {{(SumWidth-CoordWidth-11){c_real_ff[CoordWidth-1]}}, c_real_ff, 11'b0};
   assign c_imag_wide = {{(SumWidth-CoordWidth-11){c_imag_ff[CoordWidth-1]}}, c_imag_ff, 11'b0};

   // Arithmetic shifts round toward minus infinity; the imaginary shift of 23 doubles zr*zi.
   assign new_real = SumWidth'(diff_ff >>> 24) + c_real_wide;
   assign new_imag = SumWidth'(product >>> 23) + c_imag_wide;
   assign overflow = (new_real[SumWidth-1:ZWidth-1] != {(SumWidth-ZWidth+1){new_real[ZWidth-1]}})
                  || (new_imag[SumWidth-1:ZWidth-1] != {(SumWidth-ZWidth+1){new_imag[ZWidth-1]}});

   // Both squares are non-negative and at most 2^62, so the sum fits unsigned.
   assign sq_sum     = unsigned'(rr_ff) + unsigned'(product);
   assign root_start = (state_ff == S_MAG_SUM);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      steps_in     = steps_ff;
      step_in      = step_ff;
      c_real_in    = c_real_ff;
      c_imag_in    = c_imag_ff;
      z_real_in    = z_real_ff;
      z_imag_in    = z_imag_ff;
      rr_in        = rr_ff;
      diff_in      = diff_ff;
      mag_in       = mag_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_sat_in   = rsp_sat_ff;

      if (csr_valid) begin
         count_in = csr_iteration_count;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               c_real_in = req_c_real;
               c_imag_in = req_c_imag;
               z_real_in = '0;
               z_imag_in = '0;
               step_in   = '0;
               steps_in  = req_steps;
               state_in  = (req_steps == '0) ? S_MAG_R : S_SQ_R;
            end
         end
         S_SQ_R: begin
            state_in = S_SQ_I;
         end
         S_SQ_I: begin
            rr_in    = product;
            state_in = S_CROSS;
         end
         S_CROSS: begin
            diff_in  = rr_ff - product;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (overflow) begin
               // z keeps its last in-range value; the result is forced to full scale.
               mag_in   = MagMax;
               sat_in   = 1'b1;
               state_in = S_EMIT;
            end else begin
               z_real_in = new_real[ZWidth-1:0];
               z_imag_in = new_imag[ZWidth-1:0];
               step_in   = step_ff + CountWidth'(1);
               state_in  = (step_ff + CountWidth'(1) < steps_ff) ? S_SQ_R : S_MAG_R;
            end
         end
         S_MAG_R: begin
            state_in = S_MAG_I;
         end
         S_MAG_I: begin
            rr_in    = product;
            state_in = S_MAG_SUM;
         end
         S_MAG_SUM: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (root_status.done) begin
               mag_in   = root_status.root;
               sat_in   = 1'b0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mag_in   = mag_ff;
               rsp_sat_in   = sat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CountReset;
         steps_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         steps_ff     <= steps_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_real_ff  <= c_real_in;
      c_imag_ff  <= c_imag_in;
      z_real_ff  <= z_real_in;
      z_imag_ff  <= z_imag_in;
      rr_ff      <= rr_in;
      diff_ff    <= diff_in;
      mag_ff     <= mag_in;
      sat_ff     <= sat_in;
      rsp_mag_ff <= rsp_mag_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_magnitude = rsp_mag_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule
